FILE: rtl/core/lcg_rg_pkg.sv
package lcg_rg_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned BoundW = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned ReqW   = 72;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DataW-1:0] RstMult = 64'd6364136223846793005;
  localparam logic [DataW-1:0] RstIncr = 64'd1442695040888963407;
  localparam int unsigned HighShift = 33;
  localparam int unsigned HighW     = 16;

  typedef enum logic [OpW-1:0] {
    OpRaw   = 2'd0,
    OpRange = 2'd1,
    OpHigh  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMult = 2'd0,
    CfgIncr = 2'd1,
    CfgMod  = 2'd2,
    CfgSeed = 2'd3
  } cfg_e;

endpackage

FILE: rtl/core/lcg_random_generator.sv
// 64-bit linear congruential generator, bit-serial datapath.
// channels: one request item in on s_axis (op, min_value, max_value), one
// result item out on m_axis (value). the user is to write the registers
// through the cfg port only while the block is idle; the block does not
// enforce this. a seed write loads the generator state.
// steps per item, from accept to result valid:
//   raw or high-bits draw with modulus 0: multiply, then add
//   raw or high-bits draw with modulus set: multiply, add, remainder
//   ranged draw: the steps above, then the reduction by the span
//   min_value not below max_value, or unused op: straight to the result
// units: shift-add multiplier (one bit of the state per cycle), restoring
// remainder over 128-bit sum (one bit per cycle), 33-bit span remainder.
// one item is processed at a time; s_axis_tready is high only when idle.
// the result sits in an output register, so a new item is accepted while
// it waits; a finished item holds in its last step until the output
// register frees up, so a stalled receiver loses nothing.
// reset (rst_ni low) loads the default multiplier and increment, clears
// the modulus and the state and drops m_axis_tvalid.
module lcg_random_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // op [1:0], min_value [33:2], max_value [65:34], zero [71:66]
  input  logic [lcg_rg_pkg::ReqW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // value [63:0]
  output logic [lcg_rg_pkg::DataW-1:0] m_axis_tdata_o,
  input  logic                         cfg_we_i,
  input  logic [lcg_rg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lcg_rg_pkg::DataW-1:0] cfg_wdata_i
);
  import lcg_rg_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMul, StAdd, StMod, StRng, StDone
  } state_e;

  state_e               st_q;
  logic [DataW-1:0]     mult_q, incr_q, mod_q, gen_q;
  op_e                  op_q;
  logic [BoundW-1:0]    min_q;
  logic [BoundW:0]      span_q;
  logic [DataW-1:0]     hi_q, lo_q, rem_q;
  logic [BoundW:0]      rrem_q;
  logic [6:0]           cnt_q;
  logic [DataW-1:0]     res_q;
  logic [DataW-1:0]     out_q;
  logic                 ovalid_q;

  logic [OpW-1:0]       in_op;
  logic [BoundW-1:0]    in_min, in_max;
  logic                 in_acc;
  logic [DataW:0]       mul_sum;
  logic [DataW:0]       add_sum;
  logic                 mod_carry;
  logic [DataW-1:0]     mod_sh, mod_d;
  logic [BoundW+1:0]    rng_sh;
  logic [BoundW:0]      rrem_d;
  logic                 out_free;
  logic                 fin;
  logic [DataW-1:0]     fin_state;

  assign in_op  = s_axis_tdata_i[OpW-1:0];
  assign in_min = s_axis_tdata_i[OpW+BoundW-1:OpW];
  assign in_max = s_axis_tdata_i[OpW+2*BoundW-1:OpW+BoundW];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  assign s_axis_tready_o = (st_q == StIdle);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

  always_comb begin
    // multiplier step: add a on the low state bit, shift product right
    mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mult_q} : {(DataW+1){1'b0}});
    add_sum = {1'b0, lo_q} + {1'b0, incr_q};
    // remainder step over the 128-bit sum, msb first
    mod_carry = rem_q[DataW-1];
    mod_sh    = {rem_q[DataW-2:0], hi_q[DataW-1]};
    mod_d     = (mod_carry || (mod_sh >= mod_q)) ? (mod_sh - mod_q) : mod_sh;
    // remainder step by the span
    rng_sh = {rrem_q, lo_q[DataW-1]};
    rrem_d = (rng_sh >= {1'b0, span_q}) ? (BoundW+1)'(rng_sh - {1'b0, span_q}) :
             (BoundW+1)'(rng_sh);
    fin       = 1'b0;
    fin_state = add_sum[DataW-1:0];
    if (st_q == StAdd && mod_q == '0) begin
      fin = 1'b1;
    end else if (st_q == StMod && cnt_q == '0) begin
      fin       = 1'b1;
      fin_state = mod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ovalid_q <= 1'b0;
      mult_q   <= RstMult;
      incr_q   <= RstIncr;
      mod_q    <= '0;
      gen_q    <= '0;
      op_q     <= OpRaw;
      min_q    <= '0;
      span_q   <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      rem_q    <= '0;
      rrem_q   <= '0;
      cnt_q    <= '0;
      res_q    <= '0;
      out_q    <= '0;
    end else begin
      if (st_q == StDone && out_free) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CfgMult: mult_q <= cfg_wdata_i;
          CfgIncr: incr_q <= cfg_wdata_i;
          CfgMod:  mod_q  <= cfg_wdata_i;
          CfgSeed: gen_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (st_q)
        StIdle: begin
          if (in_acc) begin
            op_q   <= op_e'(in_op);
            min_q  <= in_min;
            span_q <= {1'b0, in_max} - {1'b0, in_min} + (BoundW+1)'(1);
            hi_q   <= '0;
            lo_q   <= gen_q;
            cnt_q  <= 7'd63;
            if (in_op == OpRaw || in_op == OpHigh ||
                (in_op == OpRange && in_min < in_max)) begin
              st_q <= StMul;
            end else begin
              res_q <= (in_op == OpRange) ? DataW'(in_min) : '0;
              st_q  <= StDone;
            end
          end
        end
        StMul: begin
          hi_q  <= mul_sum[DataW:1];
          lo_q  <= {mul_sum[0], lo_q[DataW-1:1]};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            st_q <= StAdd;
          end
        end
        StAdd: begin
          if (mod_q != '0) begin
            hi_q  <= hi_q + DataW'(add_sum[DataW]);
            lo_q  <= add_sum[DataW-1:0];
            rem_q <= '0;
            cnt_q <= 7'd127;
            st_q  <= StMod;
          end
        end
        StMod: begin
          if (cnt_q != '0) begin
            rem_q <= mod_d;
            hi_q  <= {hi_q[DataW-2:0], lo_q[DataW-1]};
            lo_q  <= {lo_q[DataW-2:0], 1'b0};
            cnt_q <= cnt_q - 7'd1;
          end
        end
        StRng: begin
          rrem_q <= rrem_d;
          lo_q   <= {lo_q[DataW-2:0], 1'b0};
          cnt_q  <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            res_q <= DataW'({1'b0, min_q} + rrem_d);
            st_q  <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_q <= res_q;
            st_q  <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
      if (fin) begin
        gen_q <= fin_state;
        case (op_q)
          OpRaw: begin
            res_q <= fin_state;
            st_q  <= StDone;
          end
          OpHigh: begin
            res_q <= DataW'(fin_state[HighShift+HighW-1:HighShift]);
            st_q  <= StDone;
          end
          OpRange: begin
            lo_q   <= fin_state;
            rrem_q <= '0;
            cnt_q  <= 7'd63;
            st_q   <= StRng;
          end
          default: st_q <= StDone;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/lcg_rg_checker.sv
module lcg_rg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [lcg_rg_pkg::ReqW-1:0]  s_axis_tdata_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [lcg_rg_pkg::DataW-1:0] m_axis_tdata_o,
  input logic                         cfg_we_i,
  input logic [lcg_rg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [lcg_rg_pkg::DataW-1:0] cfg_wdata_i
);
  import lcg_rg_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while busy");

  // a new result only comes out of a busy cycle
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without work");

endmodule

bind lcg_random_generator lcg_rg_checker u_lcg_rg_checker (.*);
